FILE: hw/rtl/lfsa_pkg.sv
// Shared types and constants for the lowest free slot timed allocator.
`default_nettype none

package lfsa_pkg;

  // Fixed field widths
  localparam int TIME_BITS = 20;
  localparam int ID_BITS   = 16;
  localparam int SLOT_W    = 6;

  // Booking request, one per input transfer
  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [ID_BITS-1:0]   requester_id;
  } req_t;

  // Booking result, one per request
  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic              is_target;
    logic              overflow;
  } res_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_BOOK,
    ST_OVF
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic next_row;
    logic capture;
    logic book;
    logic ovf;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;
    logic last_row;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfsa_ctrl.sv
// Controller state machine: sequences the row scan, booking and result strobe.
`default_nettype none

module lfsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lfsa_pkg::status_t status_i,
  output lfsa_pkg::cmd_t    cmd_o
);
  import lfsa_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        priority if (status_i.hit) begin
          state_d = ST_BOOK;
        end else if (status_i.last_row) begin
          state_d = ST_OVF;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_BOOK: begin
        state_d = ST_IDLE;
      end
      ST_OVF: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_CMP: begin
        cmd_o.capture  = status_i.hit;
        cmd_o.next_row = !status_i.hit && !status_i.last_row;
      end
      ST_BOOK: begin
        cmd_o.book = 1'b1;
      end
      ST_OVF: begin
        cmd_o.ovf = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lfsa_dp.sv
// Datapath: release-time memory, row compare, priority encode and result register.
`default_nettype none

module lfsa_dp #(
  parameter int SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfsa_pkg::cmd_t       cmd_i,
  output lfsa_pkg::status_t    status_o,
  input  lfsa_pkg::req_t       req_i,
  input  logic                 cfg_valid_i,
  input  logic [lfsa_pkg::ID_BITS-1:0] cfg_data_i,
  output lfsa_pkg::res_t       res_o,
  output logic                 done_o
);
  import lfsa_pkg::*;

  // Up to 16 slots share one memory row and are compared side by side
  localparam int LANES  = (SLOTS < 16) ? SLOTS : 16;
  localparam int ROWS   = (SLOTS + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = $clog2(LANES);
  localparam int IDX_W  = $clog2(ROWS * LANES + 1);

  logic [LANES-1:0][TIME_BITS-1:0] mem_q [ROWS];
  logic [LANES-1:0][TIME_BITS-1:0] rdata_q;

  req_t               req_q;
  logic [ID_BITS-1:0] target_q;
  logic [ROW_W-1:0]   row_q;
  logic [IDX_W-1:0]   row_base_q;
  logic [IDX_W-1:0]   fill_q;
  logic [LANE_W-1:0]  hit_lane_q;
  logic [IDX_W-1:0]   hit_idx_q;
  res_t               res_q;
  logic               done_q;

  logic [IDX_W-1:0]        lane_idx [LANES];
  logic [LANES-1:0]        lane_free;
  logic [LANE_W-1:0]       hit_lane;
  logic [IDX_W+SLOT_W-1:0] hit_ext;
  logic                    is_target;

  // Target register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // Request capture on an input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Row pointer; the row base tracks the slot number of lane 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      row_base_q <= '0;
    end else if (cmd_i.load) begin
      row_q      <= '0;
      row_base_q <= '0;
    end else if (cmd_i.next_row) begin
      row_q      <= row_q + ROW_W'(1);
      row_base_q <= row_base_q + IDX_W'(LANES);
    end
  end

  // Slots are always booked lowest first, so the written ones form a prefix;
  // anything at or above the fill mark is still in its reset (free) state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.book && (hit_idx_q == fill_q)) begin
      fill_q <= fill_q + IDX_W'(1);
    end
  end

  // Release-time memory: one row read, one lane written
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rdata_q <= mem_q[row_q];
    end
    if (cmd_i.book) begin
      mem_q[row_q][hit_lane_q] <= req_q.end_time;
    end
  end

  // Per-lane free test on the row just read
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_idx[l]  = row_base_q + IDX_W'(l);
      lane_free[l] = (lane_idx[l] < IDX_W'(SLOTS)) &&
                     ((lane_idx[l] >= fill_q) || (rdata_q[l] <= req_q.start_time));
    end
  end

  // Lowest free lane
  always_comb begin
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_free[l]) hit_lane = LANE_W'(l);
    end
  end

  assign status_o.hit      = |lane_free;
  assign status_o.last_row = (row_q == ROW_W'(ROWS - 1));

  // Hold the winning lane for the booking cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_lane_q <= hit_lane;
      hit_idx_q  <= row_base_q + IDX_W'(hit_lane);
    end
  end

  // Result register; slot number keeps the low bits of the index
  assign hit_ext   = {{SLOT_W{1'b0}}, hit_idx_q};
  assign is_target = (req_q.requester_id == target_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.book) begin
      res_q.slot_number <= hit_ext[SLOT_W-1:0];
      res_q.is_target   <= is_target;
      res_q.overflow    <= 1'b0;
    end else if (cmd_i.ovf) begin
      res_q.slot_number <= '0;
      res_q.is_target   <= is_target;
      res_q.overflow    <= 1'b1;
    end
  end

  // One-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.book || cmd_i.ovf;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lowest_free_slot_timed_allocator.sv
// Lowest free slot allocator with expiry, top level.
//
// A request is taken when start is high and busy is low; its result appears
// on res_o for exactly one cycle with done_o high and cannot be held off.
// Slot release times live in a memory of 16-slot rows; each row is read, then
// compared and priority encoded. A request scans the rows in order until one
// holds a free slot, then books it; if none does it takes the overflow path.
// Its result strobe follows the booking or overflow state, and busy is low in
// that same cycle, so the next request can be taken at its end.
// No clearing pass is needed after reset: a fill mark stands in for it.
// The target register may be written at any cycle with cfg_valid_i; it is
// always ready and should only be changed while the block is idle.
`default_nettype none

module lowest_free_slot_timed_allocator #(
  parameter int SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lfsa_pkg::req_t                req_i,
  output logic                          done_o,
  output lfsa_pkg::res_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfsa_pkg::ID_BITS-1:0]  cfg_data_i
);
  import lfsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  lfsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Storage and compare
  lfsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lfsa_checker.sv
// Port-level assertions for the allocator, with the bind that attaches them.
`default_nettype none

module lfsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input lfsa_pkg::res_t               res_o
);
  import lfsa_pkg::*;

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // The result strobe lasts one cycle only
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // The result comes out as the block goes idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // Busy only ends with a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // An overflow result carries slot zero
  a_ovf_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |-> (res_o.slot_number == '0))
    else $error("overflow result with nonzero slot");

endmodule

bind lowest_free_slot_timed_allocator lfsa_checker u_lfsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .res_o       (res_o)
);

`default_nettype wire
